// ===== hw/rtl/key_value_arg_lookup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Key/value argument lookup: assertion macros
// Shared helpers for the concurrent checks in the lookup unit.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_ARG_LOOKUP_UNIT_DEFINES_SVH
`define KEY_VALUE_ARG_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define KVAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define KVAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kval_pkg.sv =====
// ----------------------------------------------------------------------------
// Key/value argument lookup package
// Types, codes and default sizes shared by the lookup unit.
// ----------------------------------------------------------------------------
package kval_pkg;

    localparam int KEY_MAX_BYTES_DEF = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_LEN_W   = 6;
    localparam int OUT_FIELD_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORBIDDEN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRE    = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_VALUE  = 2'd0;
    localparam logic [1:0] ST_BARE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [4:0] {
        PH_TOKEN    = 5'b00001,
        PH_SKIP     = 5'b00010,
        PH_VFIRST   = 5'b00100,
        PH_UNQUOTED = 5'b01000,
        PH_QUOTED   = 5'b10000
    } t_phase;

endpackage

// ===== hw/rtl/key_value_arg_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Key/value argument lookup unit
// Scans a text stream for one configured key and reports its value.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                         Contents
// s         in         i_s_tvalid/o_s_tready         tdata: data_byte, tlast: last_byte
// m         out        o_m_tvalid/i_m_tready         tdata: offset, length; tuser: status
// cfg       in         i_cfg_we/i_cfg_index/data     register writes, no read-back
//
// One byte is taken per clock while no result waits; each byte is parsed in the cycle it is
// accepted, and any result is written to the output register at that edge
// and offered on the next cycle.
// A result that waits holds off the input; a result taken in the same cycle
// lets the next byte in, so beats flow back to back while results are taken.
// At most one result per stream; the stream closes on a beat with tlast set.
// Reset is synchronous, active low, and clears the parser, the configuration
// and the result valid flag.
// ----------------------------------------------------------------------------
`include "key_value_arg_lookup_unit_defines.svh"

module key_value_arg_lookup_unit #(
    parameter int KEY_MAX_BYTES = kval_pkg::KEY_MAX_BYTES_DEF,
    parameter int POSITION_BITS = kval_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] data_byte
    input  logic                              i_s_tlast,   // last_byte
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [31:0]                       o_m_tdata,   // [15:0] offset, [31:16] length
    output logic [1:0]                        o_m_tuser,   // [1:0] lookup_status
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [kval_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [kval_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int KW = kval_pkg::KEY_LEN_W;
    localparam int OW = kval_pkg::OUT_FIELD_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Configuration registers
    logic [KW-1:0]              r_key_length;
    logic [KEY_MAX_BYTES*8-1:0] r_key;
    logic [7:0]                 r_forbidden;
    logic                       r_require;

    // Parser state
    kval_pkg::t_phase           r_phase, n_phase;
    logic [POSITION_BITS-1:0]   r_pos, n_pos;
    logic [KW-1:0]              r_tok_len, n_tok_len;
    logic                       r_mismatch, n_mismatch;
    logic [POSITION_BITS-1:0]   r_vstart, n_vstart;
    logic [POSITION_BITS-1:0]   r_vcount, n_vcount;
    logic                       r_forb_seen, n_forb_seen;
    logic                       r_matched, n_matched;
    logic                       r_done, n_done;
    logic                       r_run;

    // Result register
    logic                       r_out_valid;
    logic [1:0]                 r_status;
    logic [POSITION_BITS-1:0]   r_off;
    logic [POSITION_BITS-1:0]   r_len;

    logic                       w_accept;
    logic                       w_emit;
    logic [1:0]                 w_status;
    logic [POSITION_BITS-1:0]   w_off;
    logic [POSITION_BITS-1:0]   w_len;

    logic [7:0]                 w_byte;
    logic                       w_last;
    logic                       w_blank;
    logic                       w_delim;
    logic                       w_quote;
    logic                       w_found;
    logic [KW-1:0]              w_k;
    logic [7:0]                 w_key_byte;
    logic                       w_take_bad;
    logic                       w_forb_hit;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    assign w_byte   = i_s_tdata;
    assign w_last   = i_s_tlast;
    assign w_accept = i_s_tvalid && o_s_tready;

    assign o_s_tready = r_run && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {OW'(r_len), OW'(r_off)};

    assign w_blank = (w_byte == kval_pkg::CH_SPACE) || (w_byte == kval_pkg::CH_TAB);
    assign w_delim = w_blank || (w_byte == kval_pkg::CH_EQUAL) ||
                     (w_byte == kval_pkg::CH_LF) || (w_byte == kval_pkg::CH_NUL);
    assign w_quote = (w_byte == kval_pkg::CH_QUOTE);
    assign w_found = !r_mismatch && (r_tok_len == r_key_length);
    assign w_forb_hit = (r_forbidden != 8'd0) && (w_byte == r_forbidden);

    // Key byte compared against this token byte; a new token restarts at zero.
    assign w_k = (r_phase == kval_pkg::PH_SKIP) ? '0 : r_tok_len;

    always_comb begin
        w_key_byte = 8'd0;
        for (int i = 0; i < KEY_MAX_BYTES; i++) begin
            if (w_k == KW'(i)) begin
                w_key_byte = r_key[i*8 +: 8];
            end
        end
    end

    assign w_take_bad = (w_k >= r_key_length) ||
                        ({1'b0, w_k} >= (KW+1)'(KEY_MAX_BYTES)) ||
                        (w_key_byte != w_byte);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = sat_inc(r_pos);
        n_tok_len   = r_tok_len;
        n_mismatch  = r_mismatch;
        n_vstart    = r_vstart;
        n_vcount    = r_vcount;
        n_forb_seen = r_forb_seen;
        n_matched   = r_matched;
        n_done      = r_done;
        w_emit      = 1'b0;
        w_status    = kval_pkg::ST_NONE;
        w_off       = '0;
        w_len       = '0;

        if (!r_done) begin
            case (r_phase)
                kval_pkg::PH_TOKEN: begin
                    if (w_delim) begin
                        if (w_byte != kval_pkg::CH_EQUAL) begin
                            if (w_found) begin
                                w_emit   = 1'b1;
                                w_status = r_require ? kval_pkg::ST_REJECT : kval_pkg::ST_BARE;
                            end else begin
                                n_phase = kval_pkg::PH_SKIP;
                            end
                        end else begin
                            n_matched   = w_found;
                            n_vstart    = sat_inc(r_pos);
                            n_vcount    = '0;
                            n_forb_seen = 1'b0;
                            n_phase     = kval_pkg::PH_VFIRST;
                            // Empty value at stream end.
                            if (w_last && w_found) begin
                                w_emit = 1'b1;
                                if (r_require) begin
                                    w_status = kval_pkg::ST_REJECT;
                                end else begin
                                    w_status = kval_pkg::ST_VALUE;
                                    w_off    = n_vstart;
                                end
                            end
                        end
                    end else begin
                        n_mismatch = r_mismatch || w_take_bad;
                        if (r_tok_len != '1) begin
                            n_tok_len = r_tok_len + 1'b1;
                        end
                    end
                end
                kval_pkg::PH_SKIP: begin
                    // The first byte of a token is never tested as a delimiter.
                    if (!w_blank) begin
                        n_tok_len  = KW'(1);
                        n_mismatch = w_take_bad;
                        n_phase    = kval_pkg::PH_TOKEN;
                    end
                end
                kval_pkg::PH_VFIRST, kval_pkg::PH_UNQUOTED, kval_pkg::PH_QUOTED: begin
                    if ((r_phase == kval_pkg::PH_VFIRST) && w_quote) begin
                        n_vstart = sat_inc(r_vstart);
                        n_phase  = kval_pkg::PH_QUOTED;
                        if (w_last && r_matched) begin
                            w_emit = 1'b1;
                            if (r_forb_seen || r_require) begin
                                w_status = kval_pkg::ST_REJECT;
                            end else begin
                                w_status = kval_pkg::ST_VALUE;
                                w_off    = n_vstart;
                            end
                        end
                    end else begin
                        if (r_phase == kval_pkg::PH_VFIRST) begin
                            n_phase = kval_pkg::PH_UNQUOTED;
                        end
                        // A value closes at a blank (unquoted) or a quote (quoted);
                        // at stream end the final byte is dropped.
                        if (((r_phase == kval_pkg::PH_QUOTED) ? w_quote : w_blank) || w_last)
                        begin
                            if (r_matched) begin
                                w_emit = 1'b1;
                                if (r_forb_seen || (r_require && (r_vcount == '0))) begin
                                    w_status = kval_pkg::ST_REJECT;
                                end else begin
                                    w_status = kval_pkg::ST_VALUE;
                                    w_off    = r_vstart;
                                    w_len    = r_vcount;
                                end
                            end else if (!w_last) begin
                                n_phase = kval_pkg::PH_SKIP;
                            end
                        end else begin
                            n_vcount    = sat_inc(r_vcount);
                            n_forb_seen = r_forb_seen || w_forb_hit;
                        end
                    end
                end
                default: begin
                    n_phase = kval_pkg::PH_TOKEN;
                end
            endcase
        end

        if (w_emit) begin
            n_done = 1'b1;
        end

        if (w_last) begin
            if (!w_emit && !r_done) begin
                w_emit   = 1'b1;
                w_status = kval_pkg::ST_NONE;
                w_off    = '0;
                w_len    = '0;
            end
            n_phase     = kval_pkg::PH_TOKEN;
            n_pos       = '0;
            n_tok_len   = '0;
            n_mismatch  = 1'b0;
            n_vstart    = '0;
            n_vcount    = '0;
            n_forb_seen = 1'b0;
            n_matched   = 1'b0;
            n_done      = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            r_key        <= '0;
            r_forbidden  <= 8'd0;
            r_require    <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == kval_pkg::CFG_KEY_LENGTH) begin
                r_key_length <= i_cfg_data[KW-1:0];
            end
            if (i_cfg_index == kval_pkg::CFG_FORBIDDEN) begin
                r_forbidden <= i_cfg_data[7:0];
            end
            if (i_cfg_index == kval_pkg::CFG_REQUIRE) begin
                r_require <= i_cfg_data[0];
            end
            for (int i = 0; i < KEY_MAX_BYTES; i++) begin
                if (i_cfg_index == kval_pkg::CFG_INDEX_W'(kval_pkg::CFG_KEY_LOW + (i >> 3))) begin
                    r_key[i*8 +: 8] <= i_cfg_data[(i & 7)*8 +: 8];
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_phase     <= kval_pkg::PH_TOKEN;
            r_pos       <= '0;
            r_tok_len   <= '0;
            r_mismatch  <= 1'b0;
            r_vstart    <= '0;
            r_vcount    <= '0;
            r_forb_seen <= 1'b0;
            r_matched   <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (w_accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_tok_len   <= n_tok_len;
                r_mismatch  <= n_mismatch;
                r_vstart    <= n_vstart;
                r_vcount    <= n_vcount;
                r_forb_seen <= n_forb_seen;
                r_matched   <= n_matched;
                r_done      <= n_done;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_status <= w_status;
            r_off    <= w_off;
            r_len    <= w_len;
        end
    end

    `KVAL_ASSERT_NOW(a_one_result_per_stream, w_accept && r_done, !w_emit, "extra result")
    `KVAL_ASSERT_NOW(a_end_gives_result, w_accept && w_last && !r_done, w_emit, "no end result")
    `KVAL_ASSERT_NEXT(a_stream_restart, w_accept && w_last, (r_pos == '0) && !r_done, "no restart")
    `KVAL_ASSERT_NOW(a_result_from_beat, $rose(o_m_tvalid), $past(w_accept && w_emit), "no beat")

endmodule
